// ===== sv/bwht_pkg.sv =====
// Package: shared types and constants of the burn-wire heater timer.
`timescale 1ns / 1ps
package bwht_pkg;

  localparam int unsigned HeatW    = 16;
  localparam int unsigned AttW     = 8;
  localparam int unsigned AccumW   = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [HeatW-1:0] HeatTimeRst = 16'd3000;
  localparam logic [HeatW-1:0] HeatTimeMin = 16'd1;
  localparam logic [AttW-1:0]  MaxAttRst   = 8'd1;
  localparam logic [AttW-1:0]  MaxAttMin   = 8'd1;

  typedef enum logic [1:0] {
    ModeBegin = 2'd0,
    ModeStart = 2'd1,
    ModeTick  = 2'd2,
    ModeAbort = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhHeating = 2'd1,
    PhDone    = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegHeatTime   = 1'd0,
    RegMaxAttempt = 1'd1
  } cfg_reg_e;

endpackage

// ===== sv/bwht_if.sv =====
// Interfaces: event, result and register-write channels of the heater timer.
`timescale 1ns / 1ps
interface bwht_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [bwht_pkg::HeatW-1:0]     elapsed_ms;

  modport source (output valid, mode, elapsed_ms, input ready);
  modport sink   (input valid, mode, elapsed_ms, output ready);
endinterface

interface bwht_out_if;
  logic                         valid;
  logic                         ready;
  logic                         heater_on;
  logic                         accepted;
  logic [1:0]                   phase;
  logic [bwht_pkg::AttW-1:0]    attempts_used;

  modport source (output valid, heater_on, accepted, phase, attempts_used, input ready);
  modport sink   (input valid, heater_on, accepted, phase, attempts_used, output ready);
endinterface

interface bwht_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bwht_pkg::CfgIdxW-1:0]    index;
  logic [bwht_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/burn_wire_heater_timer.sv =====
// Top level: burn-wire heater drive controller (begin/start/tick/abort events).
//
// Channels: in_i carries one event per beat (mode, elapsed_ms); out_o returns
// exactly one result beat per event (heater_on, accepted, phase,
// attempts_used); cfg_i writes heat_time_ms (index 0) or max_attempts
// (index 1) and is always ready. Writes must go in only while no event is pending; the block does not enforce this.
// Result: the result of an event is registered and valid in the cycle after its beat.
// Throughput: one event per cycle. The state update is a single 17-bit
// saturating add and compare done between the event beat and the result
// register; in_i.ready stays high while the result register is empty or
// being drained in the same cycle.
// Stall: if the receiver holds out_o.ready low, the result register keeps its
// beat and in_i.ready drops, so no event is lost or reordered.
// Reset: rst_ni clears the block to not armed, idle, heater off, zero
// attempts; heat_time_ms returns to 3000 and max_attempts to 1. No result
// is pending after reset.
`timescale 1ns / 1ps
module burn_wire_heater_timer #(
  parameter int unsigned MAX_HEAT_MS = 10000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bwht_in_if.sink       in_i,
  bwht_out_if.source    out_o,
  bwht_cfg_if.sink      cfg_i
);

  localparam logic [bwht_pkg::HeatW-1:0] MaxHeat = bwht_pkg::HeatW'(MAX_HEAT_MS);

  logic [bwht_pkg::HeatW-1:0] heat_time_q;
  logic [bwht_pkg::AttW-1:0]  max_att_q;

  logic                         armed_q, armed_d;
  bwht_pkg::phase_e             state_q, state_d;
  logic [bwht_pkg::AccumW-1:0]  accum_q, accum_d;
  logic [bwht_pkg::AttW-1:0]    attempts_q, attempts_d;
  logic                         drive_q, drive_d;
  logic                         acc_d;

  logic                         out_valid_q;
  logic                         out_heater_q;
  logic                         out_acc_q;
  bwht_pkg::phase_e             out_phase_q;
  logic [bwht_pkg::AttW-1:0]    out_att_q;

  logic                         in_beat;
  logic [bwht_pkg::HeatW-1:0]   eff_heat;
  logic [bwht_pkg::AttW-1:0]    eff_att;
  logic [bwht_pkg::AccumW:0]    sum;
  logic [bwht_pkg::AccumW-1:0]  sum_sat;
  bwht_pkg::mode_e              mode;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_time_q <= bwht_pkg::HeatTimeRst;
      max_att_q   <= bwht_pkg::MaxAttRst;
    end else if (cfg_i.valid) begin
      case (bwht_pkg::cfg_reg_e'(cfg_i.index))
        bwht_pkg::RegHeatTime:   heat_time_q <= cfg_i.data;
        bwht_pkg::RegMaxAttempt: max_att_q   <= cfg_i.data[bwht_pkg::AttW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;
  assign mode       = bwht_pkg::mode_e'(in_i.mode);

  always_comb begin
    if (heat_time_q < bwht_pkg::HeatTimeMin) begin
      eff_heat = bwht_pkg::HeatTimeMin;
    end else if (heat_time_q > MaxHeat) begin
      eff_heat = MaxHeat;
    end else begin
      eff_heat = heat_time_q;
    end
    eff_att = (max_att_q < bwht_pkg::MaxAttMin) ? bwht_pkg::MaxAttMin : max_att_q;
  end

  assign sum     = {1'b0, accum_q} + {2'b00, in_i.elapsed_ms};
  assign sum_sat = sum[bwht_pkg::AccumW] ? '1 : sum[bwht_pkg::AccumW-1:0];

  always_comb begin
    armed_d    = armed_q;
    state_d    = state_q;
    accum_d    = accum_q;
    attempts_d = attempts_q;
    drive_d    = drive_q;
    acc_d      = 1'b0;
    case (mode)
      bwht_pkg::ModeBegin: begin
        drive_d = 1'b0;
        state_d = bwht_pkg::PhIdle;
        accum_d = '0;
        armed_d = 1'b1;
      end
      bwht_pkg::ModeStart: begin
        if (armed_q && state_q == bwht_pkg::PhIdle && attempts_q < eff_att) begin
          attempts_d = attempts_q + 8'd1;
          accum_d    = '0;
          state_d    = bwht_pkg::PhHeating;
          drive_d    = 1'b1;
          acc_d      = 1'b1;
        end
      end
      bwht_pkg::ModeTick: begin
        if (state_q == bwht_pkg::PhHeating) begin
          accum_d = sum_sat;
          if (sum_sat >= {1'b0, eff_heat}) begin
            drive_d = 1'b0;
            state_d = (attempts_q < eff_att) ? bwht_pkg::PhIdle : bwht_pkg::PhDone;
          end
        end
      end
      bwht_pkg::ModeAbort: begin
        drive_d = 1'b0;
        state_d = bwht_pkg::PhDone;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      state_q     <= bwht_pkg::PhIdle;
      accum_q     <= '0;
      attempts_q  <= '0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        armed_q    <= armed_d;
        state_q    <= state_d;
        accum_q    <= accum_d;
        attempts_q <= attempts_d;
        drive_q    <= drive_d;
      end
      if (in_beat) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each event beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_heater_q <= drive_d;
      out_acc_q    <= acc_d;
      out_phase_q  <= state_d;
      out_att_q    <= attempts_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.heater_on     = out_heater_q;
  assign out_o.accepted      = out_acc_q;
  assign out_o.phase         = out_phase_q;
  assign out_o.attempts_used = out_att_q;

endmodule
